// ===== hw/rtl/vn_pkg.sv =====
// ----------------------------------------------------------------------------
// vn_pkg: shared types and constants of the 2D vector normaliser.
// Word layouts of both channels and the records passed between its stages.
// ----------------------------------------------------------------------------
`default_nettype none

package vn_pkg;

	// Number of root bits, one per square-root stage.
	localparam int unsigned SqrtSteps = 16;
	// Number of quotient bits, one per division stage.
	localparam int unsigned DivSteps = 15;

	// Input word: one vector in signed Q8.8.
	typedef struct packed {
		logic signed [15:0] vec_x;
		logic signed [15:0] vec_y;
	} vn_in_t;

	// Output word: magnitude and unit vector.
	typedef struct packed {
		logic [31:0]        length_squared;
		logic [15:0]        length;
		logic signed [15:0] unit_x;
		logic signed [15:0] unit_y;
		logic               is_zero;
	} vn_out_t;

	// Squared length with component magnitudes and signs.
	typedef struct packed {
		logic [31:0] lsq;
		logic [15:0] mag_x;
		logic [15:0] mag_y;
		logic        neg_x;
		logic        neg_y;
	} vn_sq_t;

	// The above plus the floored length.
	typedef struct packed {
		vn_sq_t      sq;
		logic [15:0] len;
	} vn_len_t;

endpackage

`default_nettype wire

// ===== hw/rtl/vn_square.sv =====
// ----------------------------------------------------------------------------
// vn_square: squared length of a vector.
// Two stages: the component squares, then their sum.
// ----------------------------------------------------------------------------
`default_nettype none

module vn_square (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_valid,
	input  wire vn_pkg::vn_in_t in_word,
	output logic                out_valid,
	output vn_pkg::vn_sq_t      out_data
);

	logic signed [31:0] sqx, sqy;
	logic [15:0] ux, uy;
	logic        valid_s1, valid_s2;
	logic [31:0] px_s1, py_s1;
	logic [15:0] mx_s1, my_s1;
	logic        nx_s1, ny_s1;
	vn_pkg::vn_sq_t data_s2;

	// Squares of the components, and the components as unsigned words.
	assign sqx = in_word.vec_x * in_word.vec_x;
	assign sqy = in_word.vec_y * in_word.vec_y;
	assign ux  = in_word.vec_x;
	assign uy  = in_word.vec_y;

	// Valid bits of both stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// Data of both stages.
	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= $unsigned(sqx);
			py_s1 <= $unsigned(sqy);
			nx_s1 <= ux[15];
			ny_s1 <= uy[15];
			mx_s1 <= ux[15] ? (~ux + 16'd1) : ux;
			my_s1 <= uy[15] ? (~uy + 16'd1) : uy;
			data_s2.lsq   <= px_s1 + py_s1;
			data_s2.mag_x <= mx_s1;
			data_s2.mag_y <= my_s1;
			data_s2.neg_x <= nx_s1;
			data_s2.neg_y <= ny_s1;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

`default_nettype wire

// ===== hw/rtl/vn_sqrt.sv =====
// ----------------------------------------------------------------------------
// vn_sqrt: floor square root of the squared length.
// One root bit per stage, restoring digit recurrence on two radicand bits.
// ----------------------------------------------------------------------------
`default_nettype none

module vn_sqrt (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_valid,
	input  wire vn_pkg::vn_sq_t in_data,
	output logic                out_valid,
	output vn_pkg::vn_len_t     out_data
);

	localparam int unsigned N = vn_pkg::SqrtSteps;

	logic           vin  [0:N-1];
	vn_pkg::vn_sq_t din  [0:N-1];
	logic [17:0]    rin  [0:N-1];
	logic [15:0]    qin  [0:N-1];
	logic           valid_s [0:N-1];
	vn_pkg::vn_sq_t data_s  [0:N-1];
	logic [17:0]    rem_s   [0:N-1];
	logic [15:0]    root_s  [0:N-1];

	genvar k;
	generate
		for (k = 0; k < N; k++) begin : g_stage
			localparam int unsigned Hi = 2 * (N - 1 - k) + 1;
			logic [19:0] cand, trial;
			logic        ge;

			// Stage inputs come from the port or from the stage before.
			if (k == 0) begin : g_first
				assign vin[k] = in_valid;
				assign din[k] = in_data;
				assign rin[k] = '0;
				assign qin[k] = '0;
			end else begin : g_next
				assign vin[k] = valid_s[k-1];
				assign din[k] = data_s[k-1];
				assign rin[k] = rem_s[k-1];
				assign qin[k] = root_s[k-1];
			end

			// Try the next root bit against the remainder.
			assign cand  = {rin[k], din[k].lsq[Hi -: 2]};
			assign trial = {2'b00, qin[k], 2'b01};
			assign ge    = (cand >= trial);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_s[k] <= 1'b0;
				end else if (en) begin
					valid_s[k] <= vin[k];
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					data_s[k] <= din[k];
					rem_s[k]  <= ge ? 18'(cand - trial) : cand[17:0];
					root_s[k] <= {qin[k][14:0], ge};
				end
			end
		end
	endgenerate

	assign out_valid   = valid_s[N-1];
	assign out_data.sq = data_s[N-1];
	assign out_data.len = root_s[N-1];

endmodule

`default_nettype wire

// ===== hw/rtl/vn_div.sv =====
// ----------------------------------------------------------------------------
// vn_div: unit vector components by restoring division.
// One quotient bit of each component per stage, then a sign and zero stage.
// ----------------------------------------------------------------------------
`default_nettype none

module vn_div (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            in_valid,
	input  wire vn_pkg::vn_len_t in_data,
	output logic                 out_valid,
	output vn_pkg::vn_out_t      out_word
);

	localparam int unsigned N = vn_pkg::DivSteps;

	logic            vin [0:N-1];
	vn_pkg::vn_len_t din [0:N-1];
	logic [15:0]     rxi [0:N-1];
	logic [15:0]     ryi [0:N-1];
	logic [N-1:0]    qxi [0:N-1];
	logic [N-1:0]    qyi [0:N-1];
	logic            valid_s [0:N-1];
	vn_pkg::vn_len_t data_s  [0:N-1];
	logic [15:0]     rx_s [0:N-1];
	logic [15:0]     ry_s [0:N-1];
	logic [N-1:0]    qx_s [0:N-1];
	logic [N-1:0]    qy_s [0:N-1];
	logic            valid_q;
	vn_pkg::vn_out_t word_q;
	logic [15:0]     ex, ey;
	logic            zero;

	genvar k;
	generate
		for (k = 0; k < N; k++) begin : g_stage
			logic [16:0] cx, cy, dv;
			logic        gx, gy, nbx, nby;

			// The dividend is the magnitude shifted up by fourteen bits; the
			// high quotient bits are known to be zero, so the first partial
			// remainder is the magnitude halved.
			if (k == 0) begin : g_first
				assign vin[k] = in_valid;
				assign din[k] = in_data;
				assign rxi[k] = {1'b0, in_data.sq.mag_x[15:1]};
				assign ryi[k] = {1'b0, in_data.sq.mag_y[15:1]};
				assign qxi[k] = '0;
				assign qyi[k] = '0;
				assign nbx    = in_data.sq.mag_x[0];
				assign nby    = in_data.sq.mag_y[0];
			end else begin : g_next
				assign vin[k] = valid_s[k-1];
				assign din[k] = data_s[k-1];
				assign rxi[k] = rx_s[k-1];
				assign ryi[k] = ry_s[k-1];
				assign qxi[k] = qx_s[k-1];
				assign qyi[k] = qy_s[k-1];
				assign nbx    = 1'b0;
				assign nby    = 1'b0;
			end

			// Shift in the next dividend bit and subtract the length if it fits.
			assign dv = {1'b0, din[k].len};
			assign cx = {rxi[k], nbx};
			assign cy = {ryi[k], nby};
			assign gx = (cx >= dv);
			assign gy = (cy >= dv);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_s[k] <= 1'b0;
				end else if (en) begin
					valid_s[k] <= vin[k];
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					data_s[k] <= din[k];
					rx_s[k]   <= gx ? 16'(cx - dv) : cx[15:0];
					ry_s[k]   <= gy ? 16'(cy - dv) : cy[15:0];
					qx_s[k]   <= {qxi[k][N-2:0], gx};
					qy_s[k]   <= {qyi[k][N-2:0], gy};
				end
			end
		end
	endgenerate

	// Apply the signs; a zero length gives zero components.
	assign zero = (data_s[N-1].len == 16'd0);
	assign ex   = 16'(qx_s[N-1]);
	assign ey   = 16'(qy_s[N-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_s[N-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_q.length_squared <= data_s[N-1].sq.lsq;
			word_q.length         <= data_s[N-1].len;
			word_q.is_zero        <= zero;
			word_q.unit_x <= zero ? 16'sd0 :
				$signed(data_s[N-1].sq.neg_x ? (~ex + 16'd1) : ex);
			word_q.unit_y <= zero ? 16'sd0 :
				$signed(data_s[N-1].sq.neg_y ? (~ey + 16'd1) : ey);
		end
	end

	assign out_valid = valid_q;
	assign out_word  = word_q;

endmodule

`default_nettype wire

// ===== hw/rtl/vector2_normalizer_core.sv =====
// ----------------------------------------------------------------------------
// vector2_normalizer_core: magnitude and unit vector of a 2D vector.
// Squares, floor square root and division in one stalled pipeline.
// ----------------------------------------------------------------------------
// Usage:
// A word on req carries one vector (vec_x, vec_y) in signed Q8.8. It is
// taken at a clock edge where req_valid is high and req_stall is low.
// Each input word yields exactly one word on rsp: squared length (Q16.16),
// floor length (Q8.8), unit components (signed Q1.14, truncated toward
// zero) and a zero flag.
// The pipeline holds, in order: the squares and their sum, the square root
// (one root bit per stage), the division (one quotient bit per stage) and
// a stage for signs and the zero case.
// One word is taken per cycle while rsp is not stalled.
// When rsp_stall holds a waiting output word, the whole pipeline freezes
// and req_stall rises in the same cycle; nothing is lost or repeated.
// Reset clears every valid bit at once; the pipeline is then empty and
// ready in the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module vector2_normalizer_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_stall,
	input  wire vn_pkg::vn_in_t  req_word,
	output logic                 rsp_valid,
	input  wire logic            rsp_stall,
	output vn_pkg::vn_out_t      rsp_word
);

	logic            adv;
	logic            sq_valid, rt_valid;
	vn_pkg::vn_sq_t  sq_data;
	vn_pkg::vn_len_t rt_data;

	// The pipeline moves unless a finished word is being held.
	assign adv       = !(rsp_valid && rsp_stall);
	assign req_stall = !adv;

	vn_square u_square (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (req_valid),
		.in_word   (req_word),
		.out_valid (sq_valid),
		.out_data  (sq_data)
	);

	vn_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (sq_valid),
		.in_data   (sq_data),
		.out_valid (rt_valid),
		.out_data  (rt_data)
	);

	vn_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (rt_valid),
		.in_data   (rt_data),
		.out_valid (rsp_valid),
		.out_word  (rsp_word)
	);

	// The zero flag agrees with the squared length.
	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_word.is_zero == (rsp_word.length_squared == 32'd0)))
		else $error("zero flag disagrees with squared length");

	// The length is a floor root: its square does not exceed the input.
	a_floor_root: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((32'(rsp_word.length) * 32'(rsp_word.length))
			<= rsp_word.length_squared))
		else $error("length exceeds the square root");

	// Unit components stay within plus or minus one.
	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_word.unit_x <= 16'sd16384 && rsp_word.unit_x >= -16'sd16384
			&& rsp_word.unit_y <= 16'sd16384 && rsp_word.unit_y >= -16'sd16384))
		else $error("unit component out of range");

	// A zero vector gives zero components.
	a_zero_unit: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_word.is_zero) |->
			(rsp_word.unit_x == 16'sd0 && rsp_word.unit_y == 16'sd0))
		else $error("zero vector with non-zero unit component");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the 2D vector normaliser.
// Directed vectors from a table, then random vectors under changing idle
// patterns. Every output word is checked against a known table result or a local model.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

	localparam int unsigned CycleLimit = 400000;
	localparam int unsigned DrainCycles = 40;
	localparam int unsigned RandomWords = 1950;

	// One directed row: the vector, and optionally its known result.
	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		bit                 known;
		vn_pkg::vn_out_t    result;
	} vector_row_t;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            req_valid = 1'b0;
	logic            req_stall;
	vn_pkg::vn_in_t  req_word = '0;
	logic            rsp_valid;
	logic            rsp_stall = 1'b0;
	vn_pkg::vn_out_t rsp_word;

	vn_pkg::vn_out_t pending_results[$];
	int unsigned fail_count = 0;
	int unsigned word_count = 0;
	int unsigned cycle_count = 0;
	int unsigned zero_count = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	bit          hold_off_request = 1'b0;
	bit          hold_off_active = 1'b0;

	vector2_normalizer_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_word  (req_word),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_word  (rsp_word)
	);

	always #5 clk = ~clk;

	// Floor square root, one root bit per pass.
	function automatic logic [31:0] floor_root(input logic [31:0] v);
		logic [31:0] rem;
		logic [31:0] root;
		logic [31:0] bitv;
		rem = v;
		root = 0;
		bitv = 32'h4000_0000;
		while (bitv > rem)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (rem >= root + bitv) begin
				rem = rem - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	// Component over floored length, truncated toward zero, in Q1.14.
	function automatic logic signed [15:0] unit_part(input logic signed [15:0] c,
			input logic [31:0] len);
		logic [31:0] mag;
		logic [31:0] q;
		mag = c < 0 ? 32'(-32'(c)) : 32'(c);
		q = (mag << 14) / len;
		return c < 0 ? 16'(-q) : 16'(q);
	endfunction

	// Expected output word of one vector.
	function automatic vn_pkg::vn_out_t normalise(input logic signed [15:0] x,
			input logic signed [15:0] y);
		vn_pkg::vn_out_t r;
		logic [31:0] len;
		r.length_squared = 32'(32'sd0 + x * x) + 32'(32'sd0 + y * y);
		len = floor_root(r.length_squared);
		r.length = len[15:0];
		if (len == 0) begin
			r.unit_x = '0;
			r.unit_y = '0;
			r.is_zero = 1'b1;
		end else begin
			r.unit_x = unit_part(x, len);
			r.unit_y = unit_part(y, len);
			r.is_zero = 1'b0;
		end
		return r;
	endfunction

	// Offers one word, holding it until accepted; expectation queued on accept.
	task automatic send_vector(input logic signed [15:0] x, input logic signed [15:0] y,
			input vn_pkg::vn_out_t result);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_word <= '{vec_x: x, vec_y: y};
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		pending_results.push_back(result);
		word_count++;
		if (result.is_zero)
			zero_count++;
	endtask

	task automatic send_checked(input logic signed [15:0] x, input logic signed [15:0] y);
		send_vector(x, y, normalise(x, y));
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Random vector: full range half the time, otherwise with small components or on an axis.
	task automatic send_random();
		logic signed [15:0] x;
		logic signed [15:0] y;
		x = 16'($urandom);
		y = 16'($urandom);
		case ($urandom_range(7))
			0: x = 16'($signed(4'($urandom)));
			1: y = 16'($signed(4'($urandom)));
			2: x = '0;
			3: begin
				x = 16'($signed(10'($urandom)));
				y = 16'($signed(10'($urandom)));
			end
			default: ;
		endcase
		send_checked(x, y);
	endtask

	// Receiver stall pattern, with a long hold-off on request.
	always @(posedge clk) begin
		if (hold_off_request && !hold_off_active) begin
			hold_off_active <= 1'b1;
			rsp_stall <= 1'b1;
			for (int i = 0; i < 200; i++)
				@(posedge clk);
			hold_off_active <= 1'b0;
			hold_off_request <= 1'b0;
			rsp_stall <= 1'b0;
		end else if (!hold_off_active) begin
			rsp_stall <= recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct;
		end
	end

	// Output checking against the oldest expectation.
	always @(posedge clk) begin
		vn_pkg::vn_out_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected output word %h", rsp_word);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (rsp_word.length_squared !== want.length_squared) begin
					$error("length_squared: expected %0d, got %0d",
						want.length_squared, rsp_word.length_squared);
					fail_count++;
				end
				if (rsp_word.length !== want.length) begin
					$error("length: expected %0d, got %0d", want.length, rsp_word.length);
					fail_count++;
				end
				if (rsp_word.unit_x !== want.unit_x) begin
					$error("unit_x: expected %0d, got %0d", want.unit_x, rsp_word.unit_x);
					fail_count++;
				end
				if (rsp_word.unit_y !== want.unit_y) begin
					$error("unit_y: expected %0d, got %0d", want.unit_y, rsp_word.unit_y);
					fail_count++;
				end
				if (rsp_word.is_zero !== want.is_zero) begin
					$error("is_zero: expected %0d, got %0d", want.is_zero, rsp_word.is_zero);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// Stimulus.
	initial begin
		vector_row_t rows[$];
		rows = '{
			'{16'sd0, 16'sd0, 1'b1, '{32'd0, 16'd0, 16'sd0, 16'sd0, 1'b1}},
			'{16'sd256, 16'sd0, 1'b1, '{32'd65536, 16'd256, 16'sd16384, 16'sd0, 1'b0}},
			'{16'sd0, -16'sd256, 1'b1, '{32'd65536, 16'd256, 16'sd0, -16'sd16384, 1'b0}},
			'{16'sd1, 16'sd0, 1'b1, '{32'd1, 16'd1, 16'sd16384, 16'sd0, 1'b0}},
			'{-16'sd1, 16'sd0, 1'b1, '{32'd1, 16'd1, -16'sd16384, 16'sd0, 1'b0}},
			'{-16'sd32768, -16'sd32768, 1'b1,
				'{32'h8000_0000, 16'd46340, -16'sd11585, -16'sd11585, 1'b0}},
			'{-16'sd32768, 16'sd0, 1'b1, '{32'h4000_0000, 16'd32768, -16'sd16384, 16'sd0, 1'b0}},
			'{16'sd32767, 16'sd32767, 1'b0, '0},
			'{16'sd32767, -16'sd32768, 1'b0, '0},
			'{16'sd1, 16'sd1, 1'b0, '0},
			'{16'sd1, -16'sd1, 1'b0, '0},
			'{16'sd3, 16'sd4, 1'b0, '0},
			'{-16'sd300, 16'sd400, 1'b0, '0},
			'{16'sd1, 16'sd32767, 1'b0, '0},
			'{16'sh5555, 16'shAAAA, 1'b0, '0},
			'{16'shAAAA, 16'sh5555, 1'b0, '0},
			'{16'sd2, 16'sd3, 1'b0, '0}
		};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].known)
				send_vector(rows[i].x, rows[i].y, rows[i].result);
			else
				send_checked(rows[i].x, rows[i].y);
		end
		wait_drained();

		// After a full drain, the long receiver hold-off under back-to-back random vectors.
		hold_off_request <= 1'b1;
		for (int i = 0; i < 100; i++)
			send_random();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = phase == 0 ? 17 : (phase == 1 ? 55 : 0);
			recv_idle_pct = phase == 0 ? 55 : (phase == 1 ? 17 : 0);
			for (int i = 0; i < (RandomWords - 100) / 3; i++)
				send_random();
		end

		wait_drained();
		repeat (DrainCycles) @(posedge clk);
		$display("Sent %0d vectors (%0d zero) in %0d cycles, three idle patterns.",
			word_count, zero_count, cycle_count);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
